>>> rtl/pbdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdr_pkg
// Shared constants and types for the per-range-bin detection rate block.
// ----------------------------------------------------------------------------
package pbdr_pkg;

    localparam int MAX_BINS_DEF   = 1024;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int BINS_CFG_W     = 11;
    localparam int SWEEP_W        = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_COUNT = 2'd1;

    localparam logic [BINS_CFG_W-1:0] BINS_RESET  = 11'd1000;
    localparam logic [SWEEP_W-1:0]    SWEEP_RESET = 16'd1000;

    localparam int CMP_W   = 18;
    localparam int FRAC_W  = 16;
    localparam int RATE_W  = FRAC_W + 1;
    localparam int STEP_W  = 4;
    localparam logic [RATE_W-1:0] Q_ONE = 17'h10000;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic hit;
        logic first;
        logic sweep_end;
        logic bin_end;
    } flags_t;

endpackage

>>> rtl/per_bin_detection_rate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_bin_detection_rate
// Per-range-bin hit counting over a block of sweeps, with hit rate output.
//
//   channel  | ports                                   | role
//   ---------+-----------------------------------------+----------------------
//   s_       | s_valid s_ready s_detection_word        | detector word in
//   m_       | m_valid m_ready m_bin_index m_hit_total | result out (last
//            | m_hit_rate m_last_bin                   | sweep only)
//   cfg_     | cfg_we cfg_index cfg_data               | register write
//
// An item with no result passes the counter stage as a queue pop and memory
// read, then a read-modify-write. An item of the last sweep does the same,
// then restoring division one quotient bit at a time, then loads the output.
// A two-entry queue lets the front accept while the back works or stalls.
// Reset clears positions and control; counter memory needs no clearing.
// ----------------------------------------------------------------------------
module per_bin_detection_rate #(
    parameter int MAX_BINS   = pbdr_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = pbdr_pkg::COUNT_BITS_DEF,
    parameter int BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [31:0]             s_detection_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [BIN_W-1:0]               m_bin_index,
    output logic [COUNT_BITS-1:0]          m_hit_total,
    output logic [pbdr_pkg::RATE_W-1:0]    m_hit_rate,
    output logic                           m_last_bin,
    input  logic                           cfg_we,
    input  logic [pbdr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pbdr_pkg::CFG_W-1:0]     cfg_data
);
    import pbdr_pkg::*;

    localparam int FLAGS_W = $bits(flags_t);
    localparam int ENTRY_W = BIN_W + FLAGS_W;

    logic [BINS_CFG_W-1:0] bins_cfg_reg;
    logic [SWEEP_W-1:0]    sweep_cfg_reg;
    logic [CMP_W-1:0]      bins_ext;
    logic [CMP_W-1:0]      nb_eff;
    logic [SWEEP_W-1:0]    ns_eff;

    logic                  push;
    logic [BIN_W-1:0]      push_bin;
    flags_t                push_flags;
    logic                  fifo_full;
    logic                  pop;
    logic                  head_valid;
    logic [ENTRY_W-1:0]    head_data;
    flags_t                head_flags;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_cfg_reg  <= BINS_RESET;
            sweep_cfg_reg <= SWEEP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BINS_IN_USE: bins_cfg_reg  <= cfg_data[BINS_CFG_W-1:0];
                REG_SWEEP_COUNT: sweep_cfg_reg <= cfg_data[SWEEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign bins_ext = CMP_W'(bins_cfg_reg);

    always_comb begin
        if (bins_ext == '0) begin
            nb_eff = CMP_W'(1);
        end else if (bins_ext > CMP_W'(MAX_BINS)) begin
            nb_eff = CMP_W'(MAX_BINS);
        end else begin
            nb_eff = bins_ext;
        end
    end

    assign ns_eff  = (sweep_cfg_reg == '0) ? SWEEP_W'(1) : sweep_cfg_reg;
    assign s_ready = !fifo_full;

    pbdr_front #(
        .BIN_W    (BIN_W)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_detection_word (s_detection_word),
        .nb_eff           (nb_eff),
        .ns_eff           (ns_eff),
        .push             (push),
        .push_bin         (push_bin),
        .push_flags       (push_flags)
    );

    pbdr_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  ({push_bin, push_flags}),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_flags = head_data[FLAGS_W-1:0];

    pbdr_back #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS),
        .BIN_W      (BIN_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_bin    (head_data[ENTRY_W-1:FLAGS_W]),
        .head_flags  (head_flags),
        .pop         (pop),
        .ns_eff      (ns_eff),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_index (m_bin_index),
        .m_hit_total (m_hit_total),
        .m_hit_rate  (m_hit_rate),
        .m_last_bin  (m_last_bin)
    );

endmodule

>>> rtl/pbdr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdr_fifo
// Short request queue between the classifier front and the counter back.
// ----------------------------------------------------------------------------
module pbdr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/pbdr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdr_front
// Accept detector words, track bin and sweep position, classify each request.
// ----------------------------------------------------------------------------
module pbdr_front #(
    parameter int BIN_W    = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [31:0]                 s_detection_word,
    input  logic [pbdr_pkg::CMP_W-1:0]  nb_eff,
    input  logic [pbdr_pkg::SWEEP_W-1:0] ns_eff,
    output logic                        push,
    output logic [BIN_W-1:0]            push_bin,
    output pbdr_pkg::flags_t            push_flags
);
    import pbdr_pkg::*;

    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [SWEEP_W-1:0] sweep_reg, sweep_next;
    logic               bin_end;
    logic               sweep_end;

    assign push      = s_valid && s_ready;
    assign bin_end   = (CMP_W'(bin_reg) + CMP_W'(1)) >= nb_eff;
    assign sweep_end = sweep_reg >= (ns_eff - SWEEP_W'(1));

    assign push_bin             = bin_reg;
    assign push_flags.hit       = (s_detection_word != '0);
    assign push_flags.first     = (sweep_reg == '0);
    assign push_flags.sweep_end = sweep_end;
    assign push_flags.bin_end   = bin_end;

    always_comb begin
        bin_next   = bin_reg;
        sweep_next = sweep_reg;
        if (push) begin
            if (bin_end) begin
                bin_next   = '0;
                sweep_next = sweep_end ? '0 : sweep_reg + SWEEP_W'(1);
            end else begin
                bin_next = bin_reg + BIN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_reg   <= '0;
            sweep_reg <= '0;
        end else begin
            bin_reg   <= bin_next;
            sweep_reg <= sweep_next;
        end
    end

endmodule

>>> rtl/pbdr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdr_back
// Update per-bin hit counters and form the rate by restoring division.
// ----------------------------------------------------------------------------
module pbdr_back #(
    parameter int MAX_BINS   = 1024,
    parameter int COUNT_BITS = 16,
    parameter int BIN_W      = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  logic [BIN_W-1:0]              head_bin,
    input  pbdr_pkg::flags_t              head_flags,
    output logic                          pop,
    input  logic [pbdr_pkg::SWEEP_W-1:0]  ns_eff,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [BIN_W-1:0]              m_bin_index,
    output logic [COUNT_BITS-1:0]         m_hit_total,
    output logic [pbdr_pkg::RATE_W-1:0]   m_hit_rate,
    output logic                          m_last_bin
);
    import pbdr_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    localparam int CMP_CW = (COUNT_BITS > SWEEP_W) ? COUNT_BITS : SWEEP_W;

    logic [COUNT_BITS-1:0] mem [MAX_BINS];
    logic [COUNT_BITS-1:0] rd_reg;

    logic [1:0]            state_reg;
    logic [BIN_W-1:0]      bin_reg;
    flags_t                flags_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  clamp_reg;
    logic [SWEEP_W-1:0]    rem_reg;
    logic [FRAC_W-1:0]     quo_reg;
    logic [STEP_W-1:0]     step_reg;

    logic                  m_valid_reg;
    logic [BIN_W-1:0]      out_bin_reg;
    logic [COUNT_BITS-1:0] out_cnt_reg;
    logic [RATE_W-1:0]     out_rate_reg;
    logic                  out_last_reg;

    logic [COUNT_BITS-1:0] cnt_new;
    logic [SWEEP_W-1:0]    half_ns;
    logic [SWEEP_W:0]      trial;
    logic                  trial_ge;
    logic                  out_load;
    logic                  mem_we;

    assign pop      = (state_reg == ST_IDLE) && head_valid;
    assign mem_we   = (state_reg == ST_UPDATE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign half_ns  = ns_eff >> 1;
    assign trial    = {rem_reg, half_ns[step_reg]};
    assign trial_ge = trial >= {1'b0, ns_eff};

    always_comb begin
        if (flags_reg.first) begin
            cnt_new = COUNT_BITS'(flags_reg.hit);
        end else if (flags_reg.hit && (rd_reg != '1)) begin
            cnt_new = rd_reg + COUNT_BITS'(1);
        end else begin
            cnt_new = rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[bin_reg] <= cnt_new;
        end
        if (pop) begin
            rd_reg <= mem[head_bin];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (head_valid) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    state_reg <= flags_reg.sweep_end ? ST_DIV : ST_IDLE;
                end
                ST_DIV: begin
                    if (step_reg == '0) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            bin_reg   <= head_bin;
            flags_reg <= head_flags;
        end
        if (state_reg == ST_UPDATE) begin
            cnt_reg   <= cnt_new;
            clamp_reg <= CMP_CW'(cnt_new) >= CMP_CW'(ns_eff);
            rem_reg   <= SWEEP_W'(cnt_new);
            quo_reg   <= '0;
            step_reg  <= STEP_W'(FRAC_W - 1);
        end
        if (state_reg == ST_DIV) begin
            rem_reg  <= trial_ge ? SWEEP_W'(trial - {1'b0, ns_eff}) : SWEEP_W'(trial);
            quo_reg  <= {quo_reg[FRAC_W-2:0], trial_ge};
            step_reg <= step_reg - STEP_W'(1);
        end
        if (out_load) begin
            out_bin_reg  <= bin_reg;
            out_cnt_reg  <= cnt_reg;
            out_rate_reg <= clamp_reg ? Q_ONE : {1'b0, quo_reg};
            out_last_reg <= flags_reg.bin_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_index = out_bin_reg;
    assign m_hit_total = out_cnt_reg;
    assign m_hit_rate  = out_rate_reg;
    assign m_last_bin  = out_last_reg;

endmodule

>>> tb/per_bin_detection_rate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_bin_detection_rate_tb
// Self-checking bench for the per-range-bin detection rate block.
//
// Detector words go in sweep by sweep. A local model keeps its own bin and
// sweep positions and its own hit counters, and queues the bin index, hit
// total, Q1.16 hit rate and last-bin flag for every word of a last sweep.
// Each request on the result side is checked against the oldest queued
// entry. Directed cases cover the reset register values, field extremes,
// zero and oversized registers, rounding, the rate clamp and registers
// shrunk in the middle of a block. A full 1024-bin sweep and random short
// blocks with random idling on both sides follow.
// ----------------------------------------------------------------------------
module per_bin_detection_rate_tb;
    import pbdr_pkg::*;

    localparam int          BIN_W        = $clog2(MAX_BINS_DEF);
    localparam int unsigned COUNT_MAX    = (1 << COUNT_BITS_DEF) - 1;
    localparam int          FULL_WORDS   = MAX_BINS_DEF;
    localparam int          RANDOM_WORDS = 826;
    localparam int          CALM_WORDS   = 150;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          STALL_LIMIT  = 1000;

    typedef struct {
        logic [BIN_W-1:0]          bin;
        logic [COUNT_BITS_DEF-1:0] total;
        logic [RATE_W-1:0]         rate;
        logic                      last;
    } rate_result_t;

    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic signed [31:0]    s_detection_word = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [BIN_W-1:0]      m_bin_index;
    logic [COUNT_BITS_DEF-1:0] m_hit_total;
    logic [RATE_W-1:0]     m_hit_rate;
    logic                  m_last_bin;
    logic                  cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index        = REG_BINS_IN_USE;
    logic [CFG_W-1:0]      cfg_data         = '0;

    // local model of the block
    logic [BINS_CFG_W-1:0]     bins_reg   = BINS_RESET;
    logic [SWEEP_W-1:0]        sweeps_reg = SWEEP_RESET;
    logic [BIN_W-1:0]          bin_pos    = '0;
    logic [SWEEP_W-1:0]        sweep_pos  = '0;
    logic [COUNT_BITS_DEF-1:0] hit_counts [MAX_BINS_DEF];
    bit                        bin_fresh  [MAX_BINS_DEF];
    rate_result_t              expected_rates [$];
    rate_result_t              oldest_rate;

    int errors       = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int reg_writes   = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    bit src_gaps     = 1'b1;
    bit sink_stalls  = 1'b1;
    bit calm         = 1'b0;

    per_bin_detection_rate u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_detection_word (s_detection_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_bin_index      (m_bin_index),
        .m_hit_total      (m_hit_total),
        .m_hit_rate       (m_hit_rate),
        .m_last_bin       (m_last_bin),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned bins_active(input logic [BINS_CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_BINS_DEF) return MAX_BINS_DEF;
        return v;
    endfunction

    function automatic void account_detection(input logic [31:0] word);
        int unsigned       nb;
        int unsigned       ns;
        int unsigned       cnt;
        longint unsigned   q;
        bit                bin_end;
        bit                sweep_end;
        rate_result_t      r;
        nb        = bins_active(bins_reg);
        ns        = (sweeps_reg == 0) ? 1 : sweeps_reg;
        bin_end   = bin_pos >= nb - 1;
        sweep_end = sweep_pos >= ns - 1;
        if (sweep_pos == 0) begin
            cnt = (word != 0);
        end else begin
            cnt = hit_counts[bin_pos];
            if (word != 0 && cnt < COUNT_MAX) cnt++;
        end
        hit_counts[bin_pos] = COUNT_BITS_DEF'(cnt);
        bin_fresh[bin_pos]  = 1'b1;
        if (sweep_end) begin
            q = cnt;
            q = ((q << FRAC_W) + ns / 2) / ns;
            if (q > Q_ONE) q = Q_ONE;
            r.bin   = bin_pos;
            r.total = COUNT_BITS_DEF'(cnt);
            r.rate  = RATE_W'(q);
            r.last  = bin_end;
            expected_rates.insert(expected_rates.size(), r);
        end
        if (bin_end) begin
            bin_pos = '0;
            if (sweep_end) begin
                sweep_pos = '0;
                foreach (bin_fresh[i]) bin_fresh[i] = 1'b0;
            end else begin
                sweep_pos = sweep_pos + 1'b1;
            end
        end else begin
            bin_pos = bin_pos + 1'b1;
        end
    endfunction

    // a bin count may only grow over counters this block already wrote
    function automatic bit bins_safe(input logic [BINS_CFG_W-1:0] v);
        int unsigned nb;
        int          i;
        nb = bins_active(v);
        if (sweep_pos == 0) return 1'b1;
        for (i = 0; i < nb; i++) begin
            if (!bin_fresh[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0, 1, 2: return 32'h0;
            3:       return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] word);
        if (src_gaps && !calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_detection_word <= word;
        do @(posedge aclk); while (!s_ready);
        account_detection(word);
        words_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_rates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_block(input bit wr_bins, input logic [CFG_W-1:0] bins_val,
                                 input bit wr_sweeps, input logic [CFG_W-1:0] sweeps_val);
        bit do_bins;
        do_bins = wr_bins && bins_safe(bins_val[BINS_CFG_W-1:0]);
        if (do_bins) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_BINS_IN_USE;
            cfg_data  <= bins_val;
            @(posedge aclk);
            bins_reg = bins_val[BINS_CFG_W-1:0];
            reg_writes++;
        end
        if (wr_sweeps) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_SWEEP_COUNT;
            cfg_data  <= sweeps_val;
            @(posedge aclk);
            sweeps_reg = sweeps_val[SWEEP_W-1:0];
            reg_writes++;
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_shrink();
        wait_idle();
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        wait_idle();
        program_block(1'b1, 16'd1, 1'b1, 16'd1);
        send_word(32'hFFFF_FFFF);
    endtask

    task automatic test_field_extremes();
        wait_idle();
        program_block(1'b1, 16'd4, 1'b1, 16'd2);
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'h5555_5555);
        send_word(32'hAAAA_AAAA);
    endtask

    task automatic test_zero_registers();
        wait_idle();
        program_block(1'b1, 16'd0, 1'b1, 16'd0);
        send_word(32'h0000_0000);
        send_word(32'h0001_0000);
    endtask

    task automatic test_rounding_and_clamp();
        wait_idle();
        program_block(1'b1, 16'd1, 1'b1, 16'd8);
        repeat (4) send_word(32'hFFFF_FFFF);
        wait_idle();
        program_block(1'b0, 16'd0, 1'b1, 16'd2);
        send_word(32'h0000_0001);
        wait_idle();
        program_block(1'b0, 16'd0, 1'b1, 16'd3);
        send_word(32'h0000_0001);
        send_word(32'h0000_0000);
        send_word(32'h0000_0000);
    endtask

    task automatic test_sweep_limit_shrink();
        wait_idle();
        program_block(1'b1, 16'd3, 1'b1, 16'hFFFF);
        send_word(32'h0000_0001);
        send_word(32'h0000_0001);
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
        wait_idle();
        program_block(1'b1, 16'd1, 1'b1, 16'd2);
        send_word(32'h0000_0001);
    endtask

    task automatic test_full_range_sweep();
        wait_idle();
        program_block(1'b1, 16'hFFFF, 1'b1, 16'd1);
        repeat (FULL_WORDS) send_word(random_word());
    endtask

    task automatic test_random_blocks();
        int unsigned  burst;
        int           start;
        logic [15:0]  bins_val;
        logic [15:0]  sweeps_val;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            wait_idle();
            bins_val = {5'($urandom), 11'($urandom_range(0, 12))};
            if ($urandom_range(0, 7) == 0) begin
                sweeps_val = 16'($urandom_range(7, 65535));
            end else begin
                sweeps_val = 16'($urandom_range(0, 6));
            end
            program_block($urandom_range(0, 3) != 0, bins_val,
                          $urandom_range(0, 3) != 0, sweeps_val);
            src_gaps    = $urandom_range(0, 2) != 0;
            sink_stalls = $urandom_range(0, 2) != 0;
            burst       = $urandom_range(1, 40);
            repeat (burst) begin
                calm = (words_sent - start) >= RANDOM_WORDS - CALM_WORDS;
                send_word(random_word());
            end
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (sink_stalls && !calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_rates.size() == 0) begin
                $error("unexpected rate result for bin %0d", m_bin_index);
                errors++;
            end else begin
                oldest_rate = expected_rates.pop_front();
                if (m_bin_index !== oldest_rate.bin) begin
                    $error("bin_index: expected %0d, got %0d", oldest_rate.bin, m_bin_index);
                    errors++;
                end
                if (m_hit_total !== oldest_rate.total) begin
                    $error("hit_total: expected %0d, got %0d", oldest_rate.total, m_hit_total);
                    errors++;
                end
                if (m_hit_rate !== oldest_rate.rate) begin
                    $error("hit_rate: expected %0d, got %0d", oldest_rate.rate, m_hit_rate);
                    errors++;
                end
                if (m_last_bin !== oldest_rate.last) begin
                    $error("last_bin: expected %0d, got %0d", oldest_rate.last, m_last_bin);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_shrink();
        test_field_extremes();
        test_zero_registers();
        test_rounding_and_clamp();
        test_sweep_limit_shrink();
        test_full_range_sweep();
        test_random_blocks();
        wait_idle();
        $display("Covered %0d detector words and %0d rate results over %0d register writes,",
                 words_sent, results_seen, reg_writes);
        $display("including a full 1024-bin sweep, clamped rates and mid-block shrinks.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> per_bin_detection_rate.f
rtl/pbdr_pkg.sv
rtl/pbdr_fifo.sv
rtl/pbdr_front.sv
rtl/pbdr_back.sv
rtl/per_bin_detection_rate.sv
tb/per_bin_detection_rate_tb.sv
